### rtl/ptw_pkg.sv
`timescale 1ns / 1ps
package ptw_pkg;

    localparam int unsigned ResN = 3;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_FAULT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CFG_PAGING  = 3'd0,
        CFG_WP      = 3'd1,
        CFG_PSE     = 3'd2,
        CFG_PGE     = 3'd3,
        CFG_DIRBASE = 3'd4
    } t_cfg_idx;

    localparam int unsigned E_PRESENT = 0;
    localparam int unsigned E_WRITE   = 1;
    localparam int unsigned E_USER    = 2;
    localparam int unsigned E_ACC     = 5;
    localparam int unsigned E_DIRTY   = 6;
    localparam int unsigned E_LARGE   = 7;
    localparam int unsigned E_GLOBAL  = 8;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] mem_addr;
        logic [31:0] mem_data;
        logic [31:0] paddr;
        logic [2:0]  fault_code;
        logic        page_writable;
        logic        page_user;
        logic        page_global;
        logic        fetch_echo;
    } t_result;

    typedef struct packed {
        logic [1:0]            n;
        t_result [ResN-1:0]    res;
    } t_bundle;

    typedef struct packed {
        logic paging_on;
        logic write_protect;
        logic large_pages_on;
        logic global_pages_on;
        logic [19:0] directory_frame;
    } t_cfg;

    // combined rights: bit1 write, bit2 user; index is entry bits 2..1
    function automatic logic [2:0] combine_rights(input logic [1:0] d, input logic [1:0] t);
        logic [2:0] r;
        begin
            unique case ({d, t})
                4'b0000, 4'b0010, 4'b1000: r = 3'd0;
                4'b1010: r = 3'd4;
                4'b1011: r = 3'd4;
                4'b1110: r = 3'd4;
                4'b1111: r = 3'd6;
                default: r = 3'd2;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/x86_page_table_walker.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// request   i_push / o_full      i_func, i_virt_addr, i_is_write, i_is_privileged,
//                                i_is_fetch, i_cpl, i_read_data
// result    o_empty / i_pop      o_kind, o_mem_addr, o_mem_data, o_paddr,
//                                o_fault_code, o_page_writable, o_page_user,
//                                o_page_global, o_fetch_echo, o_last
// config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item is taken per cycle while the bundle queue has room; each item is
// decoded in the same cycle into up to three results.
// Results leave one per cycle from the queue head while i_pop is high;
// o_full rises after QDEPTH bundles wait undelivered.
// Reset (synchronous) empties the queue, idles the walk and clears the registers.
module x86_page_table_walker #(
    parameter int unsigned QDEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_func,
    input  logic [31:0] i_virt_addr,
    input  logic        i_is_write,
    input  logic        i_is_privileged,
    input  logic        i_is_fetch,
    input  logic [1:0]  i_cpl,
    input  logic [31:0] i_read_data,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_kind,
    output logic [31:0] o_mem_addr,
    output logic [31:0] o_mem_data,
    output logic [31:0] o_paddr,
    output logic [2:0]  o_fault_code,
    output logic        o_page_writable,
    output logic        o_page_user,
    output logic        o_page_global,
    output logic        o_fetch_echo,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data
);
    import ptw_pkg::*;

    t_cfg    r_cfg;
    t_bundle bundle, head;
    t_result res;
    logic    push, q_pop, fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PAGING:  r_cfg.paging_on       <= i_cfg_data[0];
                CFG_WP:      r_cfg.write_protect   <= i_cfg_data[0];
                CFG_PSE:     r_cfg.large_pages_on  <= i_cfg_data[0];
                CFG_PGE:     r_cfg.global_pages_on <= i_cfg_data[0];
                CFG_DIRBASE: r_cfg.directory_frame <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign fire = i_push && !o_full;

    ptw_front u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_fire(fire), .i_func, .i_virt_addr,
        .i_is_write, .i_is_privileged, .i_is_fetch, .i_cpl, .i_read_data,
        .o_push(push), .o_bundle(bundle)
    );

    ptw_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_bundle(bundle), .i_pop(q_pop),
        .o_head(head), .o_full, .o_empty
    );

    ptw_back u_back (
        .i_clk, .i_rst_n, .i_head(head), .i_empty(o_empty), .i_pop,
        .o_q_pop(q_pop), .o_res(res), .o_last
    );

    assign o_kind          = res.kind;
    assign o_mem_addr      = res.mem_addr;
    assign o_mem_data      = res.mem_data;
    assign o_paddr         = res.paddr;
    assign o_fault_code    = res.fault_code;
    assign o_page_writable = res.page_writable;
    assign o_page_user     = res.page_user;
    assign o_page_global   = res.page_global;
    assign o_fetch_echo    = res.fetch_echo;
endmodule

### rtl/ptw_front.sv
`timescale 1ns / 1ps
module ptw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptw_pkg::t_cfg     i_cfg,
    input  logic              i_fire,
    input  logic              i_func,
    input  logic [31:0]       i_virt_addr,
    input  logic              i_is_write,
    input  logic              i_is_privileged,
    input  logic              i_is_fetch,
    input  logic [1:0]        i_cpl,
    input  logic [31:0]       i_read_data,
    output logic              o_push,
    output ptw_pkg::t_bundle  o_bundle
);
    import ptw_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_DIR, PH_TABLE} t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_vaddr, n_vaddr;
    logic [4:0]  r_flags, n_flags;
    logic [31:0] r_pde, n_pde;

    t_bundle     b;
    t_result     blank;
    logic        wr, user, ufault, ok, fetch;
    logic [2:0]  rights;
    logic [31:0] d, dir_addr, tab_addr, pde;
    logic [1:0]  k;

    always_comb begin
        d        = i_read_data;
        pde      = r_pde;
        wr       = r_flags[0];
        user     = (r_flags[4:3] == 2'd3) && !r_flags[1];
        ufault   = (r_flags[4:3] == 2'd3);
        fetch    = r_flags[2];
        dir_addr = {i_cfg.directory_frame, r_vaddr[31:22], 2'b00};
        tab_addr = {pde[31:12], r_vaddr[21:12], 2'b00};
        rights   = 3'd0;
        ok       = 1'b0;
        k        = 2'd0;
        n_phase  = r_phase;
        n_vaddr  = r_vaddr;
        n_flags  = r_flags;
        n_pde    = r_pde;
        blank    = '0;
        b        = '0;
        if (!i_func) begin
            n_vaddr = i_virt_addr;
            n_flags = {i_cpl, i_is_fetch, i_is_privileged, i_is_write};
            blank.fetch_echo = i_is_fetch;
            b.res[0] = blank;
            b.n = 2'd1;
            if (!i_cfg.paging_on) begin
                b.res[0].kind = KIND_DONE;
                b.res[0].paddr = i_virt_addr;
                b.res[0].page_writable = 1'b1;
                b.res[0].page_user = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                b.res[0].kind = KIND_READ;
                b.res[0].mem_addr = {i_cfg.directory_frame, i_virt_addr[31:22], 2'b00};
                n_phase = PH_DIR;
            end
        end else if (r_phase != PH_IDLE) begin
            blank.fetch_echo = fetch;
            b.res = {ResN{blank}};
            if (r_phase == PH_DIR && d[E_PRESENT] && !(d[E_LARGE] && i_cfg.large_pages_on)) begin
                n_pde = d;
                b.res[0].kind = KIND_READ;
                b.res[0].mem_addr = {d[31:12], r_vaddr[21:12], 2'b00};
                b.n = 2'd1;
                n_phase = PH_TABLE;
            end else begin
                if (r_phase == PH_DIR) rights = {d[E_USER], d[E_WRITE], 1'b0};
                else rights = combine_rights(pde[2:1], d[2:1]);
                ok = !(user && !rights[2]) &&
                     !(wr && !rights[1] && (user || i_cfg.write_protect));
                n_phase = PH_IDLE;
                if (!d[E_PRESENT] || !ok) begin
                    b.res[0].kind = KIND_FAULT;
                    b.res[0].mem_addr = r_vaddr;
                    b.res[0].fault_code = {ufault, wr, d[E_PRESENT]};
                    b.n = 2'd1;
                end else begin
                    if (r_phase == PH_DIR) begin
                        if (!d[E_ACC] || wr) begin
                            b.res[k].kind = KIND_WRITE;
                            b.res[k].mem_addr = dir_addr;
                            b.res[k].mem_data = d | (32'd1 << E_ACC) |
                                                (wr ? (32'd1 << E_DIRTY) : 32'h0);
                            k = k + 2'd1;
                        end
                        b.res[k].paddr = {d[31:22], r_vaddr[21:0]};
                    end else begin
                        if (!pde[E_ACC]) begin
                            b.res[k].kind = KIND_WRITE;
                            b.res[k].mem_addr = dir_addr;
                            b.res[k].mem_data = pde | (32'd1 << E_ACC);
                            k = k + 2'd1;
                        end
                        if (!d[E_ACC] || wr) begin
                            b.res[k].kind = KIND_WRITE;
                            b.res[k].mem_addr = tab_addr;
                            b.res[k].mem_data = d | (32'd1 << E_ACC) |
                                                (wr ? (32'd1 << E_DIRTY) : 32'h0);
                            k = k + 2'd1;
                        end
                        b.res[k].paddr = {d[31:12], r_vaddr[11:0]};
                    end
                    b.res[k].kind = KIND_DONE;
                    b.res[k].page_writable = rights[1];
                    b.res[k].page_user = rights[2];
                    b.res[k].page_global = d[E_GLOBAL] & i_cfg.global_pages_on;
                    b.n = k + 2'd1;
                end
            end
        end
    end

    assign o_push   = i_fire && (b.n != 2'd0);
    assign o_bundle = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_vaddr <= '0;
            r_flags <= '0;
            r_pde   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_vaddr <= n_vaddr;
            r_flags <= n_flags;
            r_pde   <= n_pde;
        end
    end

    a_resp_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_func && r_phase == PH_IDLE) |-> !o_push) else $error("idle response pushed");
    a_req_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_func) |-> (o_push && b.n == 2'd1)) else $error("request bundle size");
    a_table_after_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TABLE) |-> ($past(r_phase) == PH_DIR || $past(r_phase) == PH_TABLE))
        else $error("table phase without directory step");
endmodule

### rtl/ptw_queue.sv
`timescale 1ns / 1ps
module ptw_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ptw_pkg::t_bundle  i_bundle,
    input  logic              i_pop,
    output ptw_pkg::t_bundle  o_head,
    output logic              o_full,
    output logic              o_empty
);
    import ptw_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_bundle      r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
endmodule

### rtl/ptw_back.sv
`timescale 1ns / 1ps
module ptw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptw_pkg::t_bundle  i_head,
    input  logic              i_empty,
    input  logic              i_pop,
    output logic              o_q_pop,
    output ptw_pkg::t_result  o_res,
    output logic              o_last
);
    import ptw_pkg::*;

    logic [1:0] r_idx;

    assign o_res   = i_head.res[r_idx];
    assign o_last  = (r_idx == i_head.n - 2'd1);
    assign o_q_pop = i_pop && !i_empty && o_last;

    // step through the head bundle, drop it after its last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_pop && !i_empty) begin
            r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < i_head.n)) else $error("result index past bundle");
endmodule
